// ===== src/qrs_pkg.sv =====
// Shared constants, types and helpers for the quadratic root solver.
package qrs_pkg;
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int SQ_W      = WORD_BITS + 1;
    localparam int RAD_W     = 2 * SQ_W;
    localparam int REM_W     = SQ_W + 2;
    localparam int NUM_W     = WORD_BITS + 2 + FRAC_BITS;
    localparam int DEN_W     = WORD_BITS + 1;
    localparam int FRONT_LAT = 3;
    localparam int LATENCY   = FRONT_LAT + SQ_W + 1 + NUM_W + 1;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_NO_ROOT  = 3'd1;
    localparam t_status ST_ALL_ZERO = 3'd2;
    localparam t_status ST_DIV_ZERO = 3'd3;
    localparam t_status ST_SAT      = 3'd4;

    typedef struct packed {
        t_status                status;
        logic                   minus;
        logic                   lin;
        logic                   na;
        logic                   nb;
        logic                   nc;
        logic [WORD_BITS-1:0]   ma;
        logic [WORD_BITS-1:0]   mb;
        logic [WORD_BITS-1:0]   mc;
    } t_side;

    function automatic logic [WORD_BITS-1:0] mag_of(input logic [WORD_BITS-1:0] v);
        mag_of = v[WORD_BITS-1] ? (~v + 1'b1) : v;
    endfunction
endpackage

// ===== src/quadratic_root_solver_top.sv =====
// Top level of the quadratic root solver: front end, root, divide and saturation.
// Data flows through the front-end registers, the bit-per-stage root pipeline, a register,
// the bit-per-stage divide pipeline and an output register; the root is Q16.16.
// Throughput: one beat per cycle; busy stays low, results cannot be held off.
// Reset: synchronous active low, clears all valid bits; payload is not reset.
module quadratic_root_solver_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_op,
    input  logic [qrs_pkg::WORD_BITS-1:0]  i_coef_a,
    input  logic [qrs_pkg::WORD_BITS-1:0]  i_coef_b,
    input  logic [qrs_pkg::WORD_BITS-1:0]  i_coef_c,
    output logic                           o_valid,
    output logic [qrs_pkg::WORD_BITS-1:0]  o_root,
    output logic [2:0]                     o_status
);
    import qrs_pkg::*;

    localparam int W = WORD_BITS;

    logic             f_vld, q_vld, d_vld, d_neg;
    logic [RAD_W-1:0] f_rad;
    t_side            f_side, q_side;
    logic [SQ_W-1:0]  q_root;
    logic [NUM_W-1:0] d_quot;
    t_status          d_st;

    logic             r_pv, r_pneg, r_ov;
    logic [NUM_W-1:0] r_pnum;
    logic [DEN_W-1:0] r_pden;
    t_status          r_pst, r_ost;
    logic [W-1:0]     r_oroot;

    logic signed [W+2:0] bval, sx, nval;
    logic [W+1:0]        nmag;
    logic [NUM_W-1:0]    n_num, limit, mag;
    logic [DEN_W-1:0]    n_den;
    logic                n_neg;
    t_status             n_ost;
    logic [W-1:0]        n_oroot;

    assign busy = 1'b0;

    qrs_front u_front (
        .i_clk, .i_rst_n,
        .i_valid (start & ~busy),
        .i_op    (i_op),
        .i_a     (i_coef_a),
        .i_b     (i_coef_b),
        .i_c     (i_coef_c),
        .o_valid (f_vld),
        .o_rad   (f_rad),
        .o_side  (f_side)
    );

    qrs_sqrt u_sqrt (
        .i_clk, .i_rst_n,
        .i_valid (f_vld),
        .i_rad   (f_rad),
        .i_side  (f_side),
        .o_valid (q_vld),
        .o_root  (q_root),
        .o_side  (q_side)
    );

    always_comb begin
        bval = $signed({3'b000, q_side.mb});
        if (q_side.nb) begin
            bval = -bval;
        end
        sx   = $signed({2'b00, q_root});
        nval = q_side.minus ? (-bval - sx) : (-bval + sx);
        nmag = nval[W+2] ? (W+2)'(-nval) : nval[W+1:0];
        if (q_side.lin) begin
            n_num = {2'b00, q_side.mc, FRAC_BITS'(0)};
            n_den = {1'b0, q_side.mb};
            n_neg = (q_side.nc == q_side.nb);
        end else begin
            n_num = {nmag, FRAC_BITS'(0)};
            n_den = {q_side.ma, 1'b0};
            n_neg = (nval[W+2] != q_side.na);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= q_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pnum <= n_num;
        r_pden <= n_den;
        r_pneg <= n_neg;
        r_pst  <= q_side.status;
    end

    qrs_div u_div (
        .i_clk, .i_rst_n,
        .i_valid  (r_pv),
        .i_num    (r_pnum),
        .i_den    (r_pden),
        .i_neg    (r_pneg),
        .i_status (r_pst),
        .o_valid  (d_vld),
        .o_quot   (d_quot),
        .o_neg    (d_neg),
        .o_status (d_st)
    );

    always_comb begin
        limit = NUM_W'(1) << (W - 1);
        if (!d_neg) begin
            limit = limit - 1'b1;
        end
        mag   = d_quot;
        n_ost = d_st;
        if (d_quot > limit) begin
            mag   = limit;
            n_ost = ST_SAT;
        end
        n_oroot = d_neg ? (~mag[W-1:0] + 1'b1) : mag[W-1:0];
        if (d_st != ST_OK) begin
            n_oroot = '0;
            n_ost   = d_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oroot <= n_oroot;
        r_ost   <= n_ost;
    end

    assign o_valid  = r_ov;
    assign o_root   = r_oroot;
    assign o_status = r_ost;
endmodule

// ===== src/qrs_front.sv =====
// Front end: sign split, products and discriminant.
module qrs_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           i_op,
    input  logic [qrs_pkg::WORD_BITS-1:0]  i_a,
    input  logic [qrs_pkg::WORD_BITS-1:0]  i_b,
    input  logic [qrs_pkg::WORD_BITS-1:0]  i_c,
    output logic                           o_valid,
    output logic [qrs_pkg::RAD_W-1:0]      o_rad,
    output qrs_pkg::t_side                 o_side
);
    import qrs_pkg::*;

    logic [2:0]             r_vld;
    t_side                  r_s1, r_s2, r_s3;
    logic [2*WORD_BITS-1:0] r_b2, r_ac;
    logic [RAD_W-1:0]       r_rad;
    t_side                  n_s1, n_s3;
    logic [RAD_W-1:0]       n_rad, b2x, ac4;

    always_comb begin
        n_s1        = '0;
        n_s1.minus  = i_op;
        n_s1.na     = i_a[WORD_BITS-1];
        n_s1.nb     = i_b[WORD_BITS-1];
        n_s1.nc     = i_c[WORD_BITS-1];
        n_s1.ma     = mag_of(i_a);
        n_s1.mb     = mag_of(i_b);
        n_s1.mc     = mag_of(i_c);
        n_s1.lin    = (i_a == '0);
        n_s1.status = ST_OK;
        if (i_a == '0 && i_b == '0) begin
            n_s1.status = (i_c == '0) ? ST_ALL_ZERO : ST_DIV_ZERO;
        end
    end

    always_comb begin
        b2x   = {2'b00, r_b2};
        ac4   = {r_ac, 2'b00};
        n_s3  = r_s2;
        n_rad = '0;
        if (r_s2.na != r_s2.nc) begin
            n_rad = b2x + ac4;
        end else if (ac4 > b2x) begin
            if (!r_s2.lin) begin
                n_s3.status = ST_NO_ROOT;
            end
        end else begin
            n_rad = b2x - ac4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1  <= n_s1;
        r_s2  <= r_s1;
        r_b2  <= r_s1.mb * r_s1.mb;
        r_ac  <= r_s1.ma * r_s1.mc;
        r_s3  <= n_s3;
        r_rad <= n_rad;
    end

    assign o_valid = r_vld[2];
    assign o_rad   = r_rad;
    assign o_side  = r_s3;
endmodule

// ===== src/qrs_sqrt.sv =====
// Pipelined floor square root, one result bit per stage.
module qrs_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [qrs_pkg::RAD_W-1:0]  i_rad,
    input  qrs_pkg::t_side             i_side,
    output logic                       o_valid,
    output logic [qrs_pkg::SQ_W-1:0]   o_root,
    output qrs_pkg::t_side             o_side
);
    import qrs_pkg::*;

    logic             r_vld  [SQ_W];
    logic [REM_W-1:0] r_rem  [SQ_W];
    logic [SQ_W-1:0]  r_root [SQ_W];
    logic [RAD_W-1:0] r_rad  [SQ_W];
    t_side            r_side [SQ_W];

    for (genvar k = 0; k < SQ_W; k++) begin : g_st
        logic             v_in, ge;
        logic [REM_W-1:0] rem_in, rem_sh, trial;
        logic [SQ_W-1:0]  root_in;
        logic [RAD_W-1:0] rad_in;
        t_side            s_in;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign s_in    = i_side;
        end else begin : g_next
            assign v_in    = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
            assign s_in    = r_side[k-1];
        end

        always_comb begin
            rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
            trial  = {root_in, 2'b01};
            ge     = (rem_sh >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= ge ? (rem_sh - trial) : rem_sh;
            r_root[k] <= {root_in[SQ_W-2:0], ge};
            r_rad[k]  <= {rad_in[RAD_W-3:0], 2'b00};
            r_side[k] <= s_in;
        end
    end

    assign o_valid = r_vld[SQ_W-1];
    assign o_root  = r_root[SQ_W-1];
    assign o_side  = r_side[SQ_W-1];
endmodule

// ===== src/qrs_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module qrs_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [qrs_pkg::NUM_W-1:0]  i_num,
    input  logic [qrs_pkg::DEN_W-1:0]  i_den,
    input  logic                       i_neg,
    input  qrs_pkg::t_status           i_status,
    output logic                       o_valid,
    output logic [qrs_pkg::NUM_W-1:0]  o_quot,
    output logic                       o_neg,
    output qrs_pkg::t_status           o_status
);
    import qrs_pkg::*;

    logic             r_vld  [NUM_W];
    logic [DEN_W-1:0] r_rem  [NUM_W];
    logic [NUM_W-1:0] r_num  [NUM_W];
    logic [NUM_W-1:0] r_quot [NUM_W];
    logic [DEN_W-1:0] r_den  [NUM_W];
    logic             r_neg  [NUM_W];
    t_status          r_st   [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_st
        logic             v_in, neg_in, ge;
        logic [DEN_W-1:0] rem_in, den_in;
        logic [DEN_W:0]   rem_sh;
        logic [NUM_W-1:0] num_in, quot_in;
        t_status          st_in;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign num_in  = i_num;
            assign quot_in = '0;
            assign den_in  = i_den;
            assign neg_in  = i_neg;
            assign st_in   = i_status;
        end else begin : g_next
            assign v_in    = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign num_in  = r_num[k-1];
            assign quot_in = r_quot[k-1];
            assign den_in  = r_den[k-1];
            assign neg_in  = r_neg[k-1];
            assign st_in   = r_st[k-1];
        end

        always_comb begin
            rem_sh = {rem_in, num_in[NUM_W-1]};
            ge     = (rem_sh >= {1'b0, den_in});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= ge ? DEN_W'(rem_sh - {1'b0, den_in}) : rem_sh[DEN_W-1:0];
            r_num[k]  <= {num_in[NUM_W-2:0], 1'b0};
            r_quot[k] <= {quot_in[NUM_W-2:0], ge};
            r_den[k]  <= den_in;
            r_neg[k]  <= neg_in;
            r_st[k]   <= st_in;
        end
    end

    assign o_valid  = r_vld[NUM_W-1];
    assign o_quot   = r_quot[NUM_W-1];
    assign o_neg    = r_neg[NUM_W-1];
    assign o_status = r_st[NUM_W-1];
endmodule

// ===== src/qrs_checker.sv =====
// Port-level checks for the quadratic root solver and their binding.
module qrs_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           o_valid,
    input logic [qrs_pkg::WORD_BITS-1:0]  o_root,
    input logic [2:0]                     o_status
);
    import qrs_pkg::*;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("result beat missing");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##LATENCY !o_valid)
        else $error("unexpected result beat");

    a_status_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_NO_ROOT || o_status == ST_ALL_ZERO ||
                     o_status == ST_DIV_ZERO)) |-> (o_root == '0))
        else $error("root not zero on failure status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_NO_ROOT ||
                     o_status == ST_ALL_ZERO || o_status == ST_DIV_ZERO ||
                     o_status == ST_SAT))
        else $error("bad status code");
endmodule

bind quadratic_root_solver_top qrs_checker u_qrs_checker (
    .i_clk, .i_rst_n, .start, .busy, .o_valid, .o_root, .o_status
);
